// ----- design/camt_pkg.sv -----
package camt_pkg;

  localparam int MaxEntriesDef = 64;
  localparam int IdW = 8;
  localparam int IdDepth = 256;
  localparam logic [IdW-1:0] IdLimit = 8'd255;
  localparam logic [7:0] AllDays = 8'hFF;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_UPDATE = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_ENABLE = 3'd3,
    KIND_READ   = 3'd4,
    KIND_MATCH  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NO_ID     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_MATCH  = 3'd4
  } status_t;

  // One stored alarm slot.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] color;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [7:0]  repeat_days;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [7:0]  loop_count;
    logic        enabled;
  } slot_t;

  localparam int SlotW = $bits(slot_t);

  // Hour reduced modulo 24 by compare and subtract steps.
  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [7:0] t;
    t = v;
    if (t >= 8'd192) t = t - 8'd192;
    if (t >= 8'd96) t = t - 8'd96;
    if (t >= 8'd48) t = t - 8'd48;
    if (t >= 8'd24) t = t - 8'd24;
    return t[4:0];
  endfunction

  // Minute reduced modulo 60.
  function automatic logic [5:0] mod60(input logic [7:0] v);
    logic [7:0] t;
    t = v;
    if (t >= 8'd240) t = t - 8'd240;
    if (t >= 8'd120) t = t - 8'd120;
    if (t >= 8'd60) t = t - 8'd60;
    return t[5:0];
  endfunction

endpackage

// ----- design/camt_ram.sv -----
module camt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr,
  input  logic [Width-1:0]                         wdata,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr,
  output logic [Width-1:0]                         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/calendar_alarm_match_table_unit.sv -----
// Path from an accepted beat to out_valid: an add to a full table or an unused kind goes
// straight to the result, an add reads the identifier-in-use memory and skips used identifiers,
// and a lookup, match or delete scans the slots (a delete scans, then moves later slots down one per cycle).
// One item at a time: the next beat is taken the cycle after the result beat leaves.
// Reset (rst_n, synchronous, active low) clears the control state, then a pass over all 256
// entries clears the identifier-in-use memory; in_stall stays high during it.
module calendar_alarm_match_table_unit #(
  parameter int MAX_ENTRIES = camt_pkg::MaxEntriesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_entry_id,
  input  logic [15:0] in_color,
  input  logic [7:0]  in_hour,
  input  logic [7:0]  in_minute,
  input  logic [7:0]  in_repeat_days,
  input  logic [15:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [7:0]  in_loop_count,
  input  logic        in_enable_flag,
  input  logic [2:0]  in_weekday,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_id,
  output logic [15:0] out_color,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [7:0]  out_repeat_days,
  output logic [15:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [7:0]  out_loop_count,
  output logic        out_enabled
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IdAW = $clog2(camt_pkg::IdDepth);
  localparam int IdW_ = camt_pkg::IdW;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_SCAN   = 8'b00000100,
    S_CHECK  = 8'b00001000,
    S_IDRD   = 8'b00010000,
    S_IDCHK  = 8'b00100000,
    S_SHIFT  = 8'b01000000,
    S_OUT    = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  // Captured input beat.
  logic [2:0]  kind_r;
  logic [7:0]  eid_r, hour_r, minute_r, rdays_r, loop_r;
  logic [15:0] color_r, year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic        en_r;
  logic [2:0]  wd_r;

  logic [CW-1:0]  count_r;
  logic [IdW_-1:0] cand_r;
  logic [AW-1:0]  idx_r;
  logic [CW-1:0]  scan_r;
  logic [IdAW-1:0] clr_r;

  // Result register.
  logic        ov_r;
  logic [2:0]  st_r;
  camt_pkg::slot_t res_r;

  // Slot memory.
  logic                  s_we;
  logic [AW-1:0]         s_waddr, s_raddr;
  camt_pkg::slot_t       s_wdata, s_rdata;

  camt_ram #(.Width(camt_pkg::SlotW), .Depth(MAX_ENTRIES)) u_slots (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // Identifier-in-use memory.
  logic            u_we, u_wdata, u_rdata;
  logic [IdAW-1:0] u_waddr, u_raddr;

  camt_ram #(.Width(1), .Depth(camt_pkg::IdDepth)) u_used (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  logic accept;
  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign accept = in_valid && !in_stall;

  // New slot contents built from the captured beat.
  camt_pkg::slot_t new_slot;
  always_comb begin
    new_slot = '0;
    new_slot.id = cand_r;
    new_slot.color = color_r;
    new_slot.hour = camt_pkg::mod24(hour_r);
    new_slot.minute = camt_pkg::mod60(minute_r);
    new_slot.repeat_days = rdays_r;
    new_slot.year = year_r;
    new_slot.month = month_r;
    new_slot.day = day_r;
    new_slot.loop_count = loop_r;
    new_slot.enabled = 1'b1;
  end

  // Match test of a slot read back against the captured current time.
  logic [2:0] bitsel;
  logic       hit_match;
  assign bitsel = (wd_r == 3'd0) ? 3'd6 : wd_r - 3'd1;
  assign hit_match = s_rdata.enabled
    && ({3'b000, s_rdata.hour} == hour_r) && ({2'b00, s_rdata.minute} == minute_r)
    && (s_rdata.year == 16'd0 || s_rdata.year == year_r)
    && (s_rdata.month == 4'd0 || s_rdata.month == month_r)
    && (s_rdata.day == 5'd0 || s_rdata.day == day_r)
    && (s_rdata.repeat_days == camt_pkg::AllDays || s_rdata.repeat_days[bitsel]);

  logic hit;
  assign hit = (camt_pkg::kind_t'(kind_r) == camt_pkg::KIND_MATCH) ? hit_match
             : (s_rdata.id == eid_r);

  // Next slot position while moving slots down.
  logic [CW-1:0] scan_inc;
  assign scan_inc = scan_r + 1'b1;

  logic [CW-1:0]  count_nxt, scan_nxt;
  logic [IdW_-1:0] cand_nxt;
  logic [AW-1:0]  idx_nxt;
  logic [IdAW-1:0] clr_nxt;
  logic           ov_nxt;
  logic [2:0]     st_nxt;
  camt_pkg::slot_t res_nxt;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cand_nxt = cand_r;
    idx_nxt = idx_r;
    scan_nxt = scan_r;
    clr_nxt = clr_r;
    ov_nxt = ov_r && out_stall;
    st_nxt = st_r;
    res_nxt = res_r;
    s_we = 1'b0;
    s_waddr = idx_r;
    s_wdata = s_rdata;
    s_raddr = scan_r[AW-1:0];
    u_we = 1'b0;
    u_waddr = cand_r;
    u_wdata = 1'b0;
    u_raddr = cand_r;
    case (state_r)
      S_CLEAR: begin
        u_we = 1'b1;
        u_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IdAW'(camt_pkg::IdDepth - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          scan_nxt = '0;
          st_nxt = camt_pkg::ST_OK;
          res_nxt = '0;
          case (camt_pkg::kind_t'(in_kind))
            camt_pkg::KIND_ADD: begin
              if (count_r >= CW'(MAX_ENTRIES)) begin
                st_nxt = camt_pkg::ST_FULL;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_IDRD;
              end
            end
            camt_pkg::KIND_UPDATE, camt_pkg::KIND_DELETE, camt_pkg::KIND_ENABLE,
            camt_pkg::KIND_READ: begin
              st_nxt = camt_pkg::ST_NOT_FOUND;
              state_nxt = (count_r == '0) ? S_OUT : S_SCAN;
            end
            camt_pkg::KIND_MATCH: begin
              st_nxt = camt_pkg::ST_NO_MATCH;
              state_nxt = (count_r == '0) ? S_OUT : S_SCAN;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_SCAN: begin
        // Read address issued; data checked next cycle.
        idx_nxt = scan_r[AW-1:0];
        scan_nxt = scan_r + 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (hit) begin
          st_nxt = camt_pkg::ST_OK;
          case (camt_pkg::kind_t'(kind_r))
            camt_pkg::KIND_UPDATE: begin
              s_we = 1'b1;
              s_wdata = new_slot;
              s_wdata.id = s_rdata.id;
              s_wdata.enabled = s_rdata.enabled;
              state_nxt = S_OUT;
            end
            camt_pkg::KIND_ENABLE: begin
              s_we = 1'b1;
              s_wdata.enabled = en_r;
              state_nxt = S_OUT;
            end
            camt_pkg::KIND_DELETE: begin
              // Release the identifier; the slot after this one is already being read.
              u_we = 1'b1;
              u_waddr = s_rdata.id;
              if (scan_r >= count_r) begin
                count_nxt = count_r - 1'b1;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_SHIFT;
              end
            end
            default: begin
              res_nxt = s_rdata;
              state_nxt = S_OUT;
            end
          endcase
        end else if (scan_r >= count_r) begin
          state_nxt = S_OUT;
        end else begin
          idx_nxt = scan_r[AW-1:0];
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_SHIFT: begin
        // Move one slot down per cycle and read the one after it.
        s_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (scan_inc >= count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_OUT;
        end else begin
          scan_nxt = scan_inc;
          s_raddr = scan_inc[AW-1:0];
        end
      end
      S_IDRD: begin
        state_nxt = S_IDCHK;
      end
      S_IDCHK: begin
        if (cand_r >= camt_pkg::IdLimit) begin
          st_nxt = camt_pkg::ST_NO_ID;
          state_nxt = S_OUT;
        end else begin
          cand_nxt = cand_r + 1'b1;
          u_raddr = cand_r + 1'b1;
          if (!u_rdata) begin
            s_we = 1'b1;
            s_waddr = count_r[AW-1:0];
            s_wdata = new_slot;
            u_we = 1'b1;
            u_waddr = cand_r;
            u_wdata = 1'b1;
            count_nxt = count_r + 1'b1;
            res_nxt.id = cand_r;
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      count_r <= '0;
      cand_r <= IdW_'(1);
      clr_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cand_r <= cand_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Payload and scratch registers.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    scan_r <= scan_nxt;
    st_r <= st_nxt;
    res_r <= res_nxt;
    if (accept) begin
      kind_r <= in_kind;
      eid_r <= in_entry_id;
      color_r <= in_color;
      hour_r <= in_hour;
      minute_r <= in_minute;
      rdays_r <= in_repeat_days;
      year_r <= in_year;
      month_r <= in_month;
      day_r <= in_day;
      loop_r <= in_loop_count;
      en_r <= in_enable_flag;
      wd_r <= in_weekday;
    end
  end

  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_id = res_r.id;
  assign out_color = res_r.color;
  assign out_hour = res_r.hour;
  assign out_minute = res_r.minute;
  assign out_repeat_days = res_r.repeat_days;
  assign out_year = res_r.year;
  assign out_month = res_r.month;
  assign out_day = res_r.day;
  assign out_loop_count = res_r.loop_count;
  assign out_enabled = res_r.enabled;

endmodule

// ----- design/camt_checker.sv -----
module camt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status,
  input logic [7:0] out_id
);

  // A stalled result beat stays.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_id))
    else $error("result beat changed while stalled");

  // No input is taken while a result waits.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_valid |-> in_stall)
    else $error("input accepted with a result pending");

  // Failures carry identifier zero.
  a_fail_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != camt_pkg::ST_OK |-> out_id == 8'd0)
    else $error("nonzero id on failure");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind calendar_alarm_match_table_unit camt_checker u_camt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_id(out_id)
);
